FILE: src/mctq_pkg.sv
// Shared types and constants for the multi-channel touch qualifier.
package mctq_pkg;

    localparam int TOUCH_W   = 12;
    localparam int TIME_W    = 32;
    localparam int THRESH_W  = 16;
    localparam int COUNT_W   = 4;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_TIME = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TIME = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CNT  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_EN   = 4'd3;

    localparam logic [THRESH_W-1:0] CONFIRM_TIME_RST = 16'd50;
    localparam logic [THRESH_W-1:0] RELEASE_TIME_RST = 16'd200;
    localparam logic [COUNT_W-1:0]  PATTERN_CNT_RST  = 4'd4;
    localparam logic                PATTERN_EN_RST   = 1'b1;

    typedef struct packed {
        logic detected;
        logic held;
        logic released;
    } lane_evt_t;

    typedef struct packed {
        logic [THRESH_W-1:0] confirm_time_ms;
        logic [THRESH_W-1:0] release_time_ms;
        logic [COUNT_W-1:0]  pattern_count;
        logic                pattern_enable;
    } cfg_t;

    typedef struct packed {
        logic [TOUCH_W-1:0] detected_mask;
        logic [TOUCH_W-1:0] held_mask;
        logic [TOUCH_W-1:0] released_mask;
        logic [COUNT_W-1:0] touched_count;
        logic               pattern_hit;
    } result_t;

endpackage

FILE: src/mctq_ifs.sv
// Request channel interfaces for scans and results.
interface mctq_scan_if;
    logic                              valid;
    logic                              ready;
    logic [mctq_pkg::TOUCH_W-1:0]      touch_bits;
    logic [mctq_pkg::TIME_W-1:0]       now_ms;

    modport source (output valid, output touch_bits, output now_ms, input ready);
    modport sink   (input valid, input touch_bits, input now_ms, output ready);
endinterface

interface mctq_result_if;
    logic                              valid;
    logic                              ready;
    logic [mctq_pkg::TOUCH_W-1:0]      detected_mask;
    logic [mctq_pkg::TOUCH_W-1:0]      held_mask;
    logic [mctq_pkg::TOUCH_W-1:0]      released_mask;
    logic [mctq_pkg::COUNT_W-1:0]      touched_count;
    logic                              pattern_hit;

    modport source (output valid, output detected_mask, output held_mask,
                    output released_mask, output touched_count, output pattern_hit,
                    input ready);
    modport sink   (input valid, input detected_mask, input held_mask,
                    input released_mask, input touched_count, input pattern_hit,
                    output ready);
endinterface

FILE: src/mctq_lane.sv
// One channel: debounce state and event detection.
module mctq_lane
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              touch,
    input  logic [mctq_pkg::TIME_W-1:0]       now_ms,
    input  logic [mctq_pkg::THRESH_W-1:0]     confirm_time_ms,
    input  logic [mctq_pkg::THRESH_W-1:0]     release_time_ms,
    output mctq_pkg::lane_evt_t               evt
);

    logic                          confirmed_reg;
    logic                          confirmed_next;
    logic                          timing_reg;
    logic                          timing_next;
    logic [mctq_pkg::TIME_W-1:0]   start_reg;
    logic [mctq_pkg::TIME_W-1:0]   start_next;
    logic [mctq_pkg::TIME_W-1:0]   start_eff;
    logic [mctq_pkg::TIME_W-1:0]   elapsed;
    logic                          confirm_ok;
    logic                          release_ok;

    assign start_eff  = timing_reg ? start_reg : now_ms;
    assign elapsed    = now_ms - start_eff;
    assign confirm_ok = elapsed >= {{(mctq_pkg::TIME_W-mctq_pkg::THRESH_W){1'b0}},
                                    confirm_time_ms};
    assign release_ok = elapsed >= {{(mctq_pkg::TIME_W-mctq_pkg::THRESH_W){1'b0}},
                                    release_time_ms};

    always_comb
    begin
        confirmed_next = confirmed_reg;
        timing_next    = timing_reg;
        start_next     = start_reg;
        evt            = '0;
        if (touch && !confirmed_reg)
        begin
            timing_next = 1'b1;
            start_next  = start_eff;
            evt.detected = !timing_reg;
            if (confirm_ok)
            begin
                confirmed_next = 1'b1;
            end
        end
        else if (touch && confirmed_reg)
        begin
            evt.held = 1'b1;
        end
        else if (!touch && confirmed_reg && release_ok)
        begin
            confirmed_next = 1'b0;
            timing_next    = 1'b0;
            evt.released   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirmed_reg <= 1'b0;
            timing_reg    <= 1'b0;
        end
        else if (en)
        begin
            confirmed_reg <= confirmed_next;
            timing_reg    <= timing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            start_reg <= start_next;
        end
    end

endmodule

FILE: src/mctq_merge.sv
// Combines lane events into masks, touch count and pattern flag.
module mctq_merge
#(
    parameter int CHANNELS = 12
)
(
    input  mctq_pkg::lane_evt_t               evt [CHANNELS],
    input  logic [mctq_pkg::TOUCH_W-1:0]      touch_bits,
    input  mctq_pkg::cfg_t                    cfg,
    output mctq_pkg::result_t                 res
);

    localparam int USED = (CHANNELS < mctq_pkg::TOUCH_W) ? CHANNELS : mctq_pkg::TOUCH_W;

    logic [mctq_pkg::TOUCH_W-1:0] det;
    logic [mctq_pkg::TOUCH_W-1:0] held;
    logic [mctq_pkg::TOUCH_W-1:0] rel;
    logic [mctq_pkg::TOUCH_W-1:0] live;
    logic [mctq_pkg::COUNT_W-1:0] count;

    for (genvar j = 0; j < mctq_pkg::TOUCH_W; j++)
    begin : g_bit
        if (j < USED)
        begin : g_used
            assign det[j]  = evt[j].detected;
            assign held[j] = evt[j].held;
            assign rel[j]  = evt[j].released;
            assign live[j] = touch_bits[j];
        end
        else
        begin : g_unused
            assign det[j]  = 1'b0;
            assign held[j] = 1'b0;
            assign rel[j]  = 1'b0;
            assign live[j] = 1'b0;
        end
    end

    always_comb
    begin
        count = '0;
        for (int k = 0; k < mctq_pkg::TOUCH_W; k++)
        begin
            count = count + {{(mctq_pkg::COUNT_W-1){1'b0}}, live[k]};
        end
    end

    always_comb
    begin
        res.detected_mask = det;
        res.held_mask     = held;
        res.released_mask = rel;
        res.touched_count = count;
        res.pattern_hit   = cfg.pattern_enable && (count == cfg.pattern_count);
    end

endmodule

FILE: src/multi_channel_touch_qualifier.sv
// Top level of the multi-channel touch qualifier.
//
// Usage:
//   scan   : sink channel, one request per scan of raw touch bits plus a
//            millisecond timestamp.
//   result : source channel, one request per scan with detected, held and
//            released masks, the raw touch count and the pattern flag.
//   cfg_*  : write port for the thresholds and pattern setup; write only
//            while no scan is in flight.
// Each channel has its own lane; all lanes update in the same cycle and a
// merge stage builds the result, so one scan is taken every cycle that scan.ready is high.
// Each result is registered in the output register, or in the skid register on a stall.
// Throughput: one scan per cycle while scan.ready is high, set by the lane's
//   single subtract and two compares feeding the output register.
// Stall: a two-entry output stage (output register plus skid register)
//   keeps scan.ready high while one result waits; ready drops only when
//   both entries are full.
// Reset: clears every channel's confirmed and timing flags, empties the
//   output stage and loads the register defaults (50, 200, 4, 1).
module multi_channel_touch_qualifier
#(
    parameter int CHANNELS = 12
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mctq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mctq_pkg::CFG_W-1:0]           cfg_data,
    mctq_scan_if.sink                            scan,
    mctq_result_if.source                        result
);

    mctq_pkg::cfg_t              cfg_reg;
    mctq_pkg::lane_evt_t         evt [CHANNELS];
    mctq_pkg::result_t           res;
    mctq_pkg::result_t           out_data_reg;
    mctq_pkg::result_t           skid_data_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        skid_valid_reg;
    logic                        skid_valid_next;
    logic                        accept;
    logic                        out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.confirm_time_ms <= mctq_pkg::CONFIRM_TIME_RST;
            cfg_reg.release_time_ms <= mctq_pkg::RELEASE_TIME_RST;
            cfg_reg.pattern_count   <= mctq_pkg::PATTERN_CNT_RST;
            cfg_reg.pattern_enable  <= mctq_pkg::PATTERN_EN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mctq_pkg::REG_CONFIRM_TIME: cfg_reg.confirm_time_ms <= cfg_data;
                mctq_pkg::REG_RELEASE_TIME: cfg_reg.release_time_ms <= cfg_data;
                mctq_pkg::REG_PATTERN_CNT:
                    cfg_reg.pattern_count <= cfg_data[mctq_pkg::COUNT_W-1:0];
                mctq_pkg::REG_PATTERN_EN:   cfg_reg.pattern_enable <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign scan.ready = !skid_valid_reg;
    assign accept     = scan.valid && scan.ready;

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_lane
        logic touch;
        if (i < mctq_pkg::TOUCH_W)
        begin : g_in
            assign touch = scan.touch_bits[i];
        end
        else
        begin : g_none
            assign touch = 1'b0;
        end

        mctq_lane u_lane
        (
            .clk             (clk),
            .rst_n           (rst_n),
            .en              (accept),
            .touch           (touch),
            .now_ms          (scan.now_ms),
            .confirm_time_ms (cfg_reg.confirm_time_ms),
            .release_time_ms (cfg_reg.release_time_ms),
            .evt             (evt[i])
        );
    end

    mctq_merge #(.CHANNELS(CHANNELS)) u_merge
    (
        .evt        (evt),
        .touch_bits (scan.touch_bits),
        .cfg        (cfg_reg),
        .res        (res)
    );

    // output register plus skid register
    assign out_free = result.ready || !out_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            out_valid_next  = skid_valid_reg || accept;
            skid_valid_next = 1'b0;
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (accept)
            begin
                out_data_reg <= res;
            end
        end
        else if (accept)
        begin
            skid_data_reg <= res;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.detected_mask = out_data_reg.detected_mask;
    assign result.held_mask     = out_data_reg.held_mask;
    assign result.released_mask = out_data_reg.released_mask;
    assign result.touched_count = out_data_reg.touched_count;
    assign result.pattern_hit   = out_data_reg.pattern_hit;

endmodule

FILE: verif/mctq_checker.sv
// Scan/result monitor: predicts each touch qualifier result and compares it.
`timescale 1ns / 100ps

module mctq_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mctq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mctq_pkg::CFG_W-1:0]     cfg_data,
    mctq_scan_if                           scan,
    mctq_result_if                         result,
    output int                             errors,
    output int                             outstanding,
    output int                             checked,
    output int                             detect_events,
    output int                             release_events,
    output int                             pattern_hits
);

    localparam int REPORT_LIMIT = 10;

    mctq_pkg::cfg_t                      setup;
    logic [mctq_pkg::TOUCH_W-1:0]        confirmed;
    logic [mctq_pkg::TOUCH_W-1:0]        timing;
    logic [mctq_pkg::TIME_W-1:0]         start_ms [mctq_pkg::TOUCH_W];
    mctq_pkg::result_t                   expected_results [$];
    mctq_pkg::result_t                   observed;
    mctq_pkg::result_t                   predicted;

    function mctq_pkg::result_t qualify_scan(input logic [mctq_pkg::TOUCH_W-1:0] touch,
                                             input logic [mctq_pkg::TIME_W-1:0] now);
        mctq_pkg::result_t           r;
        logic [mctq_pkg::TIME_W-1:0] elapsed;
        int                          n;
        r = '0;
        n = 0;
        for (int ch = 0; ch < mctq_pkg::TOUCH_W; ch++)
        begin
            if (touch[ch])
                n++;
            if (touch[ch] && !confirmed[ch])
            begin
                if (!timing[ch])
                begin
                    timing[ch] = 1'b1;
                    start_ms[ch] = now;
                    r.detected_mask[ch] = 1'b1;
                end
                elapsed = now - start_ms[ch];
                if (elapsed >= mctq_pkg::TIME_W'(setup.confirm_time_ms))
                    confirmed[ch] = 1'b1;
            end
            else if (touch[ch])
            begin
                r.held_mask[ch] = 1'b1;
            end
            else if (confirmed[ch])
            begin
                elapsed = now - start_ms[ch];
                if (elapsed >= mctq_pkg::TIME_W'(setup.release_time_ms))
                begin
                    confirmed[ch] = 1'b0;
                    timing[ch] = 1'b0;
                    start_ms[ch] = '0;
                    r.released_mask[ch] = 1'b1;
                end
            end
        end
        r.touched_count = (n > 15) ? mctq_pkg::COUNT_W'(15) : mctq_pkg::COUNT_W'(n);
        r.pattern_hit = setup.pattern_enable &&
                        (r.touched_count == setup.pattern_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup.confirm_time_ms = mctq_pkg::CONFIRM_TIME_RST;
            setup.release_time_ms = mctq_pkg::RELEASE_TIME_RST;
            setup.pattern_count = mctq_pkg::PATTERN_CNT_RST;
            setup.pattern_enable = mctq_pkg::PATTERN_EN_RST;
            confirmed = '0;
            timing = '0;
            for (int ch = 0; ch < mctq_pkg::TOUCH_W; ch++)
                start_ms[ch] = '0;
            expected_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                observed = '{result.detected_mask, result.held_mask, result.released_mask,
                             result.touched_count, result.pattern_hit};
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display({"%0t: result request with nothing pending: ",
                                  "det %h held %h rel %h cnt %0d hit %0b"},
                                 $realtime, observed.detected_mask, observed.held_mask,
                                 observed.released_mask, observed.touched_count,
                                 observed.pattern_hit);
                end
                else
                begin
                    predicted = expected_results.pop_front();
                    checked++;
                    detect_events += $countones(predicted.detected_mask);
                    release_events += $countones(predicted.released_mask);
                    if (predicted.pattern_hit)
                        pattern_hits++;
                    if (observed.detected_mask !== predicted.detected_mask ||
                        observed.held_mask !== predicted.held_mask ||
                        observed.released_mask !== predicted.released_mask ||
                        observed.touched_count !== predicted.touched_count ||
                        observed.pattern_hit !== predicted.pattern_hit)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display({"%0t: mismatch exp det %h held %h rel %h cnt %0d ",
                                      "hit %0b | got det %h held %h rel %h cnt %0d hit %0b"},
                                     $realtime, predicted.detected_mask,
                                     predicted.held_mask, predicted.released_mask,
                                     predicted.touched_count, predicted.pattern_hit,
                                     observed.detected_mask, observed.held_mask,
                                     observed.released_mask, observed.touched_count,
                                     observed.pattern_hit);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    mctq_pkg::REG_CONFIRM_TIME:
                        setup.confirm_time_ms = cfg_data[mctq_pkg::THRESH_W-1:0];
                    mctq_pkg::REG_RELEASE_TIME:
                        setup.release_time_ms = cfg_data[mctq_pkg::THRESH_W-1:0];
                    mctq_pkg::REG_PATTERN_CNT:
                        setup.pattern_count = cfg_data[mctq_pkg::COUNT_W-1:0];
                    mctq_pkg::REG_PATTERN_EN:
                        setup.pattern_enable = cfg_data[0];
                    default: ;
                endcase
            end
            if (scan.valid && scan.ready)
                expected_results.push_back(qualify_scan(scan.touch_bits, scan.now_ms));
            outstanding = expected_results.size();
        end
    end

endmodule

FILE: verif/multi_channel_touch_qualifier_tb.sv
// Stimulus and verdict for the multi-channel touch qualifier.
`timescale 1ns / 100ps

module multi_channel_touch_qualifier_tb;

    localparam logic [mctq_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED = 4'd4;
    localparam logic [mctq_pkg::CFG_IDX_W-1:0] REG_LAST_INDEX   = 4'd15;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_SCANS    = 105;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [mctq_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mctq_pkg::CFG_W-1:0]     cfg_data;

    int fail_count;
    int outstanding;
    int checked;
    int detect_events;
    int release_events;
    int pattern_hits;

    int                           scans_sent;
    int                           settings;
    int unsigned                  step_span;
    logic [mctq_pkg::TOUCH_W-1:0] finger;
    logic [mctq_pkg::TIME_W-1:0]  clock_ms;
    bit                           no_idle;
    bit                           hold_req;

    mctq_scan_if   scan_ch ();
    mctq_result_if result_ch ();

    multi_channel_touch_qualifier dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .scan      (scan_ch),
        .result    (result_ch)
    );

    mctq_checker chk
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .scan           (scan_ch),
        .result         (result_ch),
        .errors         (fail_count),
        .outstanding    (outstanding),
        .checked        (checked),
        .detect_events  (detect_events),
        .release_events (release_events),
        .pattern_hits   (pattern_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[multi_channel_touch_qualifier] ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: random stalls plus one long hold on request
    initial
    begin
        int gap;
        result_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                gap = 1 + pick_gap();
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_scan(input logic [mctq_pkg::TOUCH_W-1:0] touch,
                             input logic [mctq_pkg::TIME_W-1:0] stamp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            scan_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        scan_ch.valid <= 1'b1;
        scan_ch.touch_bits <= touch;
        scan_ch.now_ms <= stamp;
        @(posedge clk);
        while (!scan_ch.ready)
            @(posedge clk);
        scans_sent++;
    endtask

    task automatic drain();
        scan_ch.valid <= 1'b0;
        @(negedge clk);
        wait (outstanding == 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [mctq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mctq_pkg::CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic apply_setup(input logic [mctq_pkg::THRESH_W-1:0] confirm_ms,
                               input logic [mctq_pkg::THRESH_W-1:0] release_ms,
                               input logic [mctq_pkg::COUNT_W-1:0] pcount,
                               input logic en);
        logic [mctq_pkg::CFG_W-1:0] junk;
        junk = mctq_pkg::CFG_W'($urandom_range(0, 65535));
        cfg_write(mctq_pkg::REG_CONFIRM_TIME, confirm_ms);
        cfg_write(mctq_pkg::REG_RELEASE_TIME, release_ms);
        cfg_write(mctq_pkg::REG_PATTERN_CNT, {junk[mctq_pkg::CFG_W-1:mctq_pkg::COUNT_W], pcount});
        cfg_write(mctq_pkg::REG_PATTERN_EN, {junk[mctq_pkg::CFG_W-1:1], en});
        // writes past the last register must not land anywhere
        cfg_write(mctq_pkg::CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_INDEX)),
                  ~junk);
        cfg_we <= 1'b0;
        step_span = ((confirm_ms > release_ms) ? confirm_ms : release_ms) / 4 + 4;
        settings++;
    endtask

    // mostly press/hold/lift sequences per finger, some noise and raw random scans
    task automatic random_scan();
        logic [mctq_pkg::TOUCH_W-1:0] touch;
        int                           r;
        if ($urandom_range(0, 9) == 0)
        begin
            touch = mctq_pkg::TOUCH_W'($urandom_range(0, 4095));
        end
        else
        begin
            for (int ch = 0; ch < mctq_pkg::TOUCH_W; ch++)
                if ($urandom_range(0, 7) == 0)
                    finger[ch] = ~finger[ch];
            touch = finger;
            for (int ch = 0; ch < mctq_pkg::TOUCH_W; ch++)
                if ($urandom_range(0, 31) == 0)
                    touch[ch] = ~touch[ch];
        end
        r = $urandom_range(0, 99);
        if (r >= 8)
            clock_ms += $urandom_range(1, step_span);
        else if (r >= 5)
            clock_ms += $urandom();
        send_scan(touch, clock_ms);
    endtask

    initial
    begin
        logic [mctq_pkg::THRESH_W-1:0] confirm_v;
        logic [mctq_pkg::THRESH_W-1:0] release_v;
        logic [mctq_pkg::COUNT_W-1:0]  pcount_v;
        logic                          en_v;
        scan_ch.valid <= 1'b0;
        scan_ch.touch_bits <= '0;
        scan_ch.now_ms <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        finger = '0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        step_span = 16;
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset thresholds: detect, confirm, hold, early and timely release
        send_scan(12'h000, 32'd0);
        send_scan(12'hFFF, 32'd10);
        send_scan(12'hFFF, 32'd60);
        send_scan(12'hFFF, 32'd61);
        send_scan(12'h000, 32'd100);
        send_scan(12'h000, 32'd210);
        send_scan(12'h00F, 32'd300);
        send_scan(12'h00F, 32'd300);
        send_scan(12'h000, 32'd301);
        send_scan(12'h00F, 32'd400);
        send_scan(12'h000, 32'd499);
        send_scan(12'h000, 32'd500);
        // timestamp wrap
        send_scan(12'h800, 32'hFFFF_FFE0);
        send_scan(12'h800, 32'h0000_0012);
        send_scan(12'h800, 32'h0000_0013);
        send_scan(12'h000, 32'h0000_00A7);
        send_scan(12'h000, 32'h0000_00A8);

        // zero thresholds, unreachable pattern count
        drain();
        apply_setup(16'd0, 16'd0, 4'd13, 1'b1);
        send_scan(12'hAAA, 32'd1000);
        send_scan(12'h555, 32'd1000);
        send_scan(12'hFFF, 32'd1000);

        // maximum thresholds, pattern disabled
        drain();
        apply_setup(16'hFFFF, 16'hFFFF, 4'd0, 1'b0);
        send_scan(12'h000, 32'd2000);
        send_scan(12'h000, 32'd1000 + 32'd65534);
        send_scan(12'h000, 32'd1000 + 32'd65535);
        send_scan(12'h001, 32'd70000);

        drain();
        apply_setup(16'd100, 16'd100, 4'd0, 1'b1);
        send_scan(12'h000, 32'd70000);
        send_scan(12'hFFF, 32'd70000);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            case (p)
                0: apply_setup(16'd0, 16'd0, 4'd0, 1'b1);
                1: apply_setup(16'hFFFF, 16'hFFFF, 4'd12, 1'b1);
                2: apply_setup(16'd1, 16'hFFFF, 4'd15, 1'b1);
                3: apply_setup(16'hFFFF, 16'd0, 4'd4, 1'b0);
                default:
                begin
                    confirm_v = ($urandom_range(0, 9) == 0)
                              ? mctq_pkg::THRESH_W'($urandom_range(0, 65535))
                              : mctq_pkg::THRESH_W'($urandom_range(0, 300));
                    release_v = ($urandom_range(0, 9) == 0)
                              ? mctq_pkg::THRESH_W'($urandom_range(0, 65535))
                              : mctq_pkg::THRESH_W'($urandom_range(0, 300));
                    pcount_v = mctq_pkg::COUNT_W'($urandom_range(0, 15));
                    en_v = 1'($urandom_range(0, 1));
                    apply_setup(confirm_v, release_v, pcount_v, en_v);
                end
            endcase
            clock_ms = (p == 2) ? 32'hFFFF_F000 : $urandom();
            if (p == 5)
                hold_req = 1'b1;
            for (int k = 0; k < PHASE_SCANS; k++)
            begin
                no_idle = (p == 5 && k < 40) || (p == 6 && k < 50);
                random_scan();
            end
            no_idle = 1'b0;
        end

        drain();
        repeat (5) @(posedge clk);
        $display("Covered %0d scans over %0d register settings, %0d results checked.",
                 scans_sent, settings, checked);
        $display("Saw %0d channel detects, %0d releases and %0d pattern hits.",
                 detect_events, release_events, pattern_hits);
        if (fail_count == 0 && outstanding == 0)
            $display("[multi_channel_touch_qualifier] OK");
        else
            $display("[multi_channel_touch_qualifier] ERROR");
        $finish;
    end

endmodule

FILE: multi_channel_touch_qualifier.f
src/mctq_pkg.sv
src/mctq_ifs.sv
src/mctq_lane.sv
src/mctq_merge.sv
src/multi_channel_touch_qualifier.sv
verif/mctq_checker.sv
verif/multi_channel_touch_qualifier_tb.sv
